// File: rtl/core/ftfn_pkg.sv
// ----------------------------------------------------------------------------
// ftfn_pkg
// Shared types and constants for the fan triangulator with flat normals.
// ----------------------------------------------------------------------------
package ftfn_pkg;

	localparam int TEX_WIDTH   = 16;
	localparam int SEEN_WIDTH  = 2;
	localparam int QUEUE_DEPTH = 2;

	// corner count at which a face starts emitting fan triangles
	localparam logic [SEEN_WIDTH-1:0] FAN_START = SEEN_WIDTH'(2);

	// which vertex of the current triangle goes out
	typedef enum logic [1:0] {
		VSEL_FIRST,
		VSEL_PREV,
		VSEL_CUR
	} vsel_t;

	// job: first/prev/cur positions, prev-first and cur-first diffs, three texcoords
	function automatic int job_width(input int cw);
		return 9 * cw + 6 * (cw + 1) + 6 * TEX_WIDTH;
	endfunction

endpackage

// File: rtl/core/ftfn_corner_if.sv
// ----------------------------------------------------------------------------
// ftfn_corner_if
// Input channel: one polygon corner per beat.
// ----------------------------------------------------------------------------
interface ftfn_corner_if
	import ftfn_pkg::*;
#(
	parameter int COORD_WIDTH = 16
) ();
	logic                          valid;
	logic                          ready;
	logic signed [COORD_WIDTH-1:0] corner_x;
	logic signed [COORD_WIDTH-1:0] corner_y;
	logic signed [COORD_WIDTH-1:0] corner_z;
	logic [TEX_WIDTH-1:0]          corner_u;
	logic [TEX_WIDTH-1:0]          corner_v;
	logic                          last_corner;

	modport source (
		output valid, corner_x, corner_y, corner_z, corner_u, corner_v, last_corner,
		input  ready
	);
	modport sink (
		input  valid, corner_x, corner_y, corner_z, corner_u, corner_v, last_corner,
		output ready
	);
endinterface

// File: rtl/core/ftfn_vert_if.sv
// ----------------------------------------------------------------------------
// ftfn_vert_if
// Output channel: one triangle vertex with face normal per beat.
// ----------------------------------------------------------------------------
interface ftfn_vert_if
	import ftfn_pkg::*;
#(
	parameter int COORD_WIDTH = 16
) ();
	logic                            valid;
	logic                            ready;
	logic signed [COORD_WIDTH-1:0]   vert_x;
	logic signed [COORD_WIDTH-1:0]   vert_y;
	logic signed [COORD_WIDTH-1:0]   vert_z;
	logic signed [2*COORD_WIDTH+1:0] normal_x;
	logic signed [2*COORD_WIDTH+1:0] normal_y;
	logic signed [2*COORD_WIDTH+1:0] normal_z;
	logic [TEX_WIDTH-1:0]            vert_u;
	logic [TEX_WIDTH-1:0]            vert_v;
	logic                            triangle_end;

	modport source (
		output valid, vert_x, vert_y, vert_z, normal_x, normal_y, normal_z,
		       vert_u, vert_v, triangle_end,
		input  ready
	);
	modport sink (
		input  valid, vert_x, vert_y, vert_z, normal_x, normal_y, normal_z,
		       vert_u, vert_v, triangle_end,
		output ready
	);
endinterface

// File: rtl/core/ftfn_front.sv
// ----------------------------------------------------------------------------
// ftfn_front
// Takes corners, tracks first and previous corner of the face, and pushes a
// triangle job (positions, edge vectors, texcoords) from the third corner on.
// ----------------------------------------------------------------------------
module ftfn_front
	import ftfn_pkg::*;
#(
	parameter int COORD_WIDTH = 16
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	ftfn_corner_if.sink                          corner,
	output logic                                 push_valid,
	input  logic                                 push_ready,
	output logic [job_width(COORD_WIDTH)-1:0]    push_data
);
	localparam int CW = COORD_WIDTH;

	typedef logic [2:0][CW-1:0]        pos_t;
	typedef logic [2:0][CW:0]          diff_t;
	typedef logic [1:0][TEX_WIDTH-1:0] tex_t;
	typedef struct packed {
		pos_t  first_pos;
		pos_t  prev_pos;
		pos_t  cur_pos;
		diff_t a;
		diff_t b;
		tex_t  first_tex;
		tex_t  prev_tex;
		tex_t  cur_tex;
	} job_t;

	pos_t                  first_pos_q, prev_pos_q, cur_pos;
	tex_t                  first_tex_q, prev_tex_q, cur_tex;
	logic [SEEN_WIDTH-1:0] seen_q, seen_nxt;
	logic                  fire;
	job_t                  job;

	assign cur_pos = {corner.corner_z, corner.corner_y, corner.corner_x};
	assign cur_tex = {corner.corner_v, corner.corner_u};

	assign corner.ready = push_ready;
	assign fire         = corner.valid && push_ready;
	assign push_valid   = fire && (seen_q == FAN_START);

	always_comb begin
		job.first_pos = first_pos_q;
		job.prev_pos  = prev_pos_q;
		job.cur_pos   = cur_pos;
		job.first_tex = first_tex_q;
		job.prev_tex  = prev_tex_q;
		job.cur_tex   = cur_tex;
		for (int i = 0; i < 3; i++) begin
			job.a[i] = (CW+1)'($signed(prev_pos_q[i])) - (CW+1)'($signed(first_pos_q[i]));
			job.b[i] = (CW+1)'($signed(cur_pos[i])) - (CW+1)'($signed(first_pos_q[i]));
		end
	end

	assign push_data = job;

	always_comb begin
		if (corner.last_corner) begin
			seen_nxt = '0;
		end else if (seen_q < FAN_START) begin
			seen_nxt = seen_q + SEEN_WIDTH'(1);
		end else begin
			seen_nxt = seen_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q      <= '0;
			first_pos_q <= '0;
			first_tex_q <= '0;
			prev_pos_q  <= '0;
			prev_tex_q  <= '0;
		end else if (fire) begin
			if (seen_q == '0) begin
				first_pos_q <= cur_pos;
				first_tex_q <= cur_tex;
			end
			prev_pos_q <= cur_pos;
			prev_tex_q <= cur_tex;
			seen_q     <= seen_nxt;
		end
	end

	a_face_restart: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && corner.last_corner) |=> (seen_q == '0))
		else $error("corner count not cleared after last corner");

endmodule

// File: rtl/core/ftfn_queue.sv
// ----------------------------------------------------------------------------
// ftfn_queue
// Short job queue between front and back.
// ----------------------------------------------------------------------------
module ftfn_queue
	import ftfn_pkg::*;
#(
	parameter int WIDTH = 8,
	parameter int DEPTH = QUEUE_DEPTH
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push_valid,
	output logic             push_ready,
	input  logic [WIDTH-1:0] push_data,
	output logic             pop_valid,
	input  logic             pop_ready,
	output logic [WIDTH-1:0] pop_data
);
	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             push, pop;

	assign push_ready = (count_q != CNT_W'(DEPTH));
	assign pop_valid  = (count_q != '0);
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;
	assign pop_data   = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

	a_count_up: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |=> (count_q == $past(count_q) + CNT_W'(1)))
		else $error("queue count did not advance on push");

endmodule

// File: rtl/core/ftfn_back.sv
// ----------------------------------------------------------------------------
// ftfn_back
// Cross product in two stages (products, then differences) and a vertex
// sequencer that sends first, previous and current corner out one per beat.
// ----------------------------------------------------------------------------
module ftfn_back
	import ftfn_pkg::*;
#(
	parameter int COORD_WIDTH = 16
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 tex_en,
	input  logic                                 pop_valid,
	output logic                                 pop_ready,
	input  logic [job_width(COORD_WIDTH)-1:0]    pop_data,
	ftfn_vert_if.source                          vert
);
	localparam int CW = COORD_WIDTH;
	localparam int NW = 2 * COORD_WIDTH + 2;

	typedef logic [2:0][CW-1:0]        pos_t;
	typedef logic [2:0][CW:0]          diff_t;
	typedef logic [1:0][TEX_WIDTH-1:0] tex_t;
	typedef struct packed {
		pos_t  first_pos;
		pos_t  prev_pos;
		pos_t  cur_pos;
		diff_t a;
		diff_t b;
		tex_t  first_tex;
		tex_t  prev_tex;
		tex_t  cur_tex;
	} job_t;

	job_t                 pop_job;
	logic signed [CW:0]   da [3];
	logic signed [CW:0]   db [3];

	logic                 s1_valid_q;
	job_t                 job_s1;
	logic signed [NW-1:0] prod_s1 [6];

	logic                 s2_valid_q;
	job_t                 job_s2;
	logic signed [NW-1:0] nrm_s2 [3];
	vsel_t                idx_s2, idx_nxt;

	logic                 s1_take, s2_take, out_free;
	pos_t                 sel_pos;
	tex_t                 sel_tex;

	logic                 out_valid_q;
	pos_t                 out_pos_q;
	logic signed [NW-1:0] out_nrm_q [3];
	tex_t                 out_tex_q;
	logic                 out_end_q;

	assign pop_job = job_t'(pop_data);

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			da[i] = $signed(pop_job.a[i]);
			db[i] = $signed(pop_job.b[i]);
		end
	end

	assign out_free  = !out_valid_q || vert.ready;
	assign s2_take   = !s2_valid_q || (out_free && (idx_s2 == VSEL_CUR));
	assign s1_take   = !s1_valid_q || s2_take;
	assign pop_ready = s1_take;

	// stage 1: the six partial products
	always_ff @(posedge clk) begin
		if (s1_take && pop_valid) begin
			job_s1     <= pop_job;
			prod_s1[0] <= NW'(da[1]) * NW'(db[2]);
			prod_s1[1] <= NW'(da[2]) * NW'(db[1]);
			prod_s1[2] <= NW'(da[2]) * NW'(db[0]);
			prod_s1[3] <= NW'(da[0]) * NW'(db[2]);
			prod_s1[4] <= NW'(da[0]) * NW'(db[1]);
			prod_s1[5] <= NW'(da[1]) * NW'(db[0]);
		end
	end

	// stage 2: normal, held while its three vertices go out
	always_ff @(posedge clk) begin
		if (s2_take && s1_valid_q) begin
			job_s2    <= job_s1;
			nrm_s2[0] <= prod_s1[0] - prod_s1[1];
			nrm_s2[1] <= prod_s1[2] - prod_s1[3];
			nrm_s2[2] <= prod_s1[4] - prod_s1[5];
		end
	end

	always_comb begin
		unique case (idx_s2)
			VSEL_FIRST: idx_nxt = VSEL_PREV;
			VSEL_PREV:  idx_nxt = VSEL_CUR;
			VSEL_CUR:   idx_nxt = VSEL_FIRST;
			default:    idx_nxt = VSEL_FIRST;
		endcase
	end

	always_comb begin
		unique case (idx_s2)
			VSEL_FIRST: begin
				sel_pos = job_s2.first_pos;
				sel_tex = job_s2.first_tex;
			end
			VSEL_PREV: begin
				sel_pos = job_s2.prev_pos;
				sel_tex = job_s2.prev_tex;
			end
			default: begin
				sel_pos = job_s2.cur_pos;
				sel_tex = job_s2.cur_tex;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q  <= 1'b0;
			s2_valid_q  <= 1'b0;
			idx_s2      <= VSEL_FIRST;
			out_valid_q <= 1'b0;
		end else begin
			if (s1_take) begin
				s1_valid_q <= pop_valid;
			end
			if (s2_take) begin
				s2_valid_q <= s1_valid_q;
				idx_s2     <= VSEL_FIRST;
			end else if (out_free) begin
				idx_s2 <= idx_nxt;
			end
			if (out_free) begin
				out_valid_q <= s2_valid_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && s2_valid_q) begin
			out_pos_q <= sel_pos;
			out_tex_q <= tex_en ? sel_tex : '0;
			out_end_q <= (idx_s2 == VSEL_CUR);
			for (int i = 0; i < 3; i++) begin
				out_nrm_q[i] <= nrm_s2[i];
			end
		end
	end

	assign vert.valid        = out_valid_q;
	assign vert.vert_x       = out_pos_q[0];
	assign vert.vert_y       = out_pos_q[1];
	assign vert.vert_z       = out_pos_q[2];
	assign vert.normal_x     = out_nrm_q[0];
	assign vert.normal_y     = out_nrm_q[1];
	assign vert.normal_z     = out_nrm_q[2];
	assign vert.vert_u       = out_tex_q[0];
	assign vert.vert_v       = out_tex_q[1];
	assign vert.triangle_end = out_end_q;

	a_tri_close: assert property (@(posedge clk) disable iff (!arst_n)
		(s2_valid_q && out_free && (idx_s2 == VSEL_CUR)) |=> (out_valid_q && vert.triangle_end))
		else $error("third vertex not marked as triangle end");

	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_valid_q && !s2_take) |=> (s1_valid_q && $stable(prod_s1[0]) && $stable(prod_s1[5])))
		else $error("product stage changed while stalled");

endmodule

// File: rtl/core/fan_triangulator_flat_normals_core.sv
// ----------------------------------------------------------------------------
// fan_triangulator_flat_normals_core
// A corner's job goes from the front through the job queue, the product stage,
// the normal stage and the output register to its first vertex beat. A corner that
// closes a fan triangle sends three vertex beats through the output register.
// Reset: arst_n clears the face state, the job queue and the pipeline;
// texcoord_enable resets to 1.
// ----------------------------------------------------------------------------
module fan_triangulator_flat_normals_core
	import ftfn_pkg::*;
#(
	parameter int COORD_WIDTH = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_wdata,
	ftfn_corner_if.sink corner,
	ftfn_vert_if.source vert
);
	localparam int JOB_W = job_width(COORD_WIDTH);

	logic             texcoord_enable_q;
	logic             push_valid, push_ready, pop_valid, pop_ready;
	logic [JOB_W-1:0] push_data, pop_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			texcoord_enable_q <= 1'b1;
		end else if (cfg_we) begin
			texcoord_enable_q <= cfg_wdata;
		end
	end

	ftfn_front #(
		.COORD_WIDTH(COORD_WIDTH)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.corner     (corner),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data)
	);

	ftfn_queue #(
		.WIDTH(JOB_W),
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_data   (pop_data)
	);

	ftfn_back #(
		.COORD_WIDTH(COORD_WIDTH)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.tex_en    (texcoord_enable_q),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.pop_data  (pop_data),
		.vert      (vert)
	);

endmodule
